// ----- hdl/wts_pkg.sv -----
// Package with shared types, constants and helpers of the window temperature statistics block.
`timescale 1ns / 1ps

package wts_pkg;

  // Sample format: signed Q7.4 degrees Celsius.
  localparam int SAMPLE_W = 12;
  localparam int FRAC_W   = 4;
  localparam int BYTE_W   = 8;
  localparam int BEAT_W   = 3;

  // Tags that precede each value in the serial byte stream.
  localparam logic [BYTE_W-1:0] TAG_LATEST = 8'd240;
  localparam logic [BYTE_W-1:0] TAG_MAX    = 8'd241;
  localparam logic [BYTE_W-1:0] TAG_MIN    = 8'd242;
  localparam logic [BYTE_W-1:0] TAG_MEAN   = 8'd243;

  // Output beat positions within one run of eight bytes.
  localparam logic [BEAT_W-1:0] BEAT_TAG_LATEST = 3'd0;
  localparam logic [BEAT_W-1:0] BEAT_LATEST     = 3'd1;
  localparam logic [BEAT_W-1:0] BEAT_TAG_MAX    = 3'd2;
  localparam logic [BEAT_W-1:0] BEAT_MAX        = 3'd3;
  localparam logic [BEAT_W-1:0] BEAT_TAG_MIN    = 3'd4;
  localparam logic [BEAT_W-1:0] BEAT_MIN        = 3'd5;
  localparam logic [BEAT_W-1:0] BEAT_TAG_MEAN   = 3'd6;
  localparam logic [BEAT_W-1:0] BEAT_MEAN       = 3'd7;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Truncate a Q7.4 value toward zero to whole degrees and keep the low byte.
  function automatic logic [BYTE_W-1:0] whole_byte(input logic signed [SAMPLE_W-1:0] q);
    logic signed [SAMPLE_W-1:0] adj;
    adj = q[SAMPLE_W-1] ? (q + SAMPLE_W'(15)) : q;
    return adj[FRAC_W+BYTE_W-1:FRAC_W];
  endfunction

endpackage

// ----- hdl/wts_if.sv -----
// Stream interfaces for the sample input and the serial byte output.
`timescale 1ns / 1ps

interface wts_in_if import wts_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wts_out_if import wts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ----- hdl/wts_ring.sv -----
// Sample ring memory with one valid bit per slot so that unwritten slots read as zero.
`timescale 1ns / 1ps

module wts_ring import wts_pkg::*; #(
  parameter int DEPTH = 100
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic signed [SAMPLE_W-1:0]       wr_data,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic signed [SAMPLE_W-1:0]       rd_data
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           valid;

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits are cleared at reset; a slot becomes valid on its first write.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read; a slot never written reads as zero.
  always_ff @(posedge clk) begin
    rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

// ----- hdl/wts_div.sv -----
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps

module wts_div import wts_pkg::*; #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic [NUM_W-1:0]  quotient,
  output div_stat_t         stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One trial subtraction of the shifted remainder.
  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    fits  = (trial >= {1'b0, den});
  end

  // Datapath: remainder and dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  // Step counter and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- hdl/window_temperature_stats.sv -----
// Top level: sliding-window latest, maximum, minimum and mean of temperature samples.
//
//   Channel  Role    Beat payload          Accepted when
//   samples  sink    sample (Q7.4, 12 b)   valid && ready
//   stats    source  out_byte, last        valid && ready
//
// One sample is stored, then the ring is scanned through its single read port,
// the serial divider forms the mean, and eight output beats follow; output
// stalls add to this. Reset clears the valid bits of the ring at once, so no
// clearing pass is needed. A stalled output holds the current byte; samples is
// not ready until the last byte of the run has been taken.
`timescale 1ns / 1ps

module window_temperature_stats import wts_pkg::*; #(
  parameter int WINDOW = 100
) (
  input  logic       clk,
  input  logic       rst,
  wts_in_if.sink     samples,
  wts_out_if.source  stats
);

  localparam int AW    = $clog2(WINDOW);
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int DEN_W = CW + FRAC_W;

  state_t state;
  state_t state_next;

  logic [AW-1:0]              write_slot;
  logic [CW-1:0]              stored_count;
  logic [CW-1:0]              scan_cnt;
  logic [BEAT_W-1:0]          beat;
  logic signed [SAMPLE_W-1:0] latest;
  logic signed [SAMPLE_W-1:0] mx;
  logic signed [SAMPLE_W-1:0] mn;
  logic signed [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]           sum_mag;
  logic [BYTE_W-1:0]          mean_byte;
  logic [BYTE_W-1:0]          q_byte;

  logic                       in_fire;
  logic                       out_fire;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SUM_W-1:0]    rd_ext;
  logic [SUM_W-1:0]           quotient;
  div_stat_t                  div_stat;

  assign in_fire  = samples.valid && samples.ready;
  assign out_fire = stats.valid && stats.ready;

  wts_ring #(.DEPTH(WINDOW)) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_fire),
    .wr_addr (write_slot),
    .wr_data (samples.sample),
    .rd_addr (scan_cnt[AW-1:0]),
    .rd_data (rd_data)
  );

  wts_div #(.NUM_W(SUM_W), .DEN_W(DEN_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DIV_START),
    .dividend (sum_mag),
    .divisor  ({stored_count, FRAC_W'(0)}),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    stats.valid   = 1'b0;
    case (state)
      ST_IDLE: begin
        samples.ready = 1'b1;
        if (in_fire) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == CW'(WINDOW)) begin
          state_next = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        stats.valid = 1'b1;
        if (out_fire && beat == BEAT_MEAN) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Ring pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      stored_count <= '0;
    end else if (in_fire) begin
      write_slot   <= (write_slot == AW'(WINDOW - 1)) ? '0 : write_slot + AW'(1);
      if (stored_count != CW'(WINDOW)) begin
        stored_count <= stored_count + CW'(1);
      end
    end
  end

  // Scan counter issues reads; the beat counter walks the output run.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      beat     <= '0;
    end else begin
      if (in_fire) begin
        scan_cnt <= '0;
      end else if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + CW'(1);
      end
      if (state == ST_IDLE) begin
        beat <= '0;
      end else if (out_fire) begin
        beat <= beat + BEAT_W'(1);
      end
    end
  end

  assign rd_ext = {{(SUM_W - SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};

  // Magnitude of the finished sum, loaded by the divider as it starts.
  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  // Accumulate sum, maximum and minimum from the registered read data.
  // Slot zero seeds max and min; later slots count only when positive.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      latest <= samples.sample;
    end
    if (state == ST_SCAN && scan_cnt != '0) begin
      if (scan_cnt == CW'(1)) begin
        sum <= rd_ext;
        mx  <= rd_data;
        mn  <= rd_data;
      end else begin
        sum <= sum + rd_ext;
        if (rd_data > 0 && rd_data > mx) begin
          mx <= rd_data;
        end
        if (rd_data > 0 && rd_data < mn) begin
          mn <= rd_data;
        end
      end
    end
    if (div_stat.done) begin
      mean_byte <= sum[SUM_W-1] ? (~q_byte + BYTE_W'(1)) : q_byte;
    end
  end

  assign q_byte = quotient[BYTE_W-1:0];

  // Output byte selection for the current beat.
  always_comb begin
    case (beat)
      BEAT_TAG_LATEST: stats.out_byte = TAG_LATEST;
      BEAT_LATEST:     stats.out_byte = whole_byte(latest);
      BEAT_TAG_MAX:    stats.out_byte = TAG_MAX;
      BEAT_MAX:        stats.out_byte = whole_byte(mx);
      BEAT_TAG_MIN:    stats.out_byte = TAG_MIN;
      BEAT_MIN:        stats.out_byte = whole_byte(mn);
      BEAT_TAG_MEAN:   stats.out_byte = TAG_MEAN;
      BEAT_MEAN:       stats.out_byte = mean_byte;
      default:         stats.out_byte = TAG_LATEST;
    endcase
    stats.last = (beat == BEAT_MEAN);
  end

endmodule
